// ----- design/lcs_pkg.sv -----
package lcs_pkg;

  localparam int LenWidth = 7;
  localparam logic [LenWidth-1:0] LEN_MAX = 7'd127;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_END    = 2'd3
  } cmd_t;

  typedef logic [LenWidth-1:0] len_t;

  typedef struct packed {
    logic query;
    logic row_clear;
    logic ref_clear;
  } cell_ctl_t;

endpackage

// ----- design/longest_common_substring_length.sv -----
// Longest common substring length of a stored reference and a streamed query.
// Input channel (in_valid, in_stall, command, symbol) takes one item per cycle
// while in_stall is low, for clear, append and query-byte commands. Each
// reference byte lives in its own cell of a chain, and every active cell
// updates its run length in the same cycle. An end-query item produces one
// result (match_length, reference_truncated) on the output channel (out_valid,
// out_stall). The per-cell maxima ripple down the chain one cell per cycle, so
// the result is loaded only at the end of the drain; in_stall is high during
// the drain. All other commands produce no result.
// Reset clears the reference, the row, the maximum and the truncation flag,
// and leaves the output channel empty.
// A held result stays stable while out_stall is high, and new items are still
// accepted; a second end-query item waits in its final cycle until the first
// result has been taken.
module longest_common_substring_length #(
  parameter int MAX_REF = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] command,
  input  logic [7:0] symbol,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] match_length,
  output logic       reference_truncated
);

  localparam int CW = $clog2(MAX_REF + 1);
  localparam int DW = (MAX_REF > 1) ? $clog2(MAX_REF) : 1;

  typedef enum logic {ST_RUN, ST_DRAIN} state_t;

  state_t             state;
  logic [CW-1:0]      ref_count;
  logic [DW-1:0]      drain_cnt;
  logic               overflow;
  logic               accept;
  logic               append;
  logic               load_result;
  lcs_pkg::cell_ctl_t ctl;
  lcs_pkg::len_t      run_chain [MAX_REF+1];
  lcs_pkg::len_t      carry_chain [MAX_REF+1];

  assign in_stall    = (state == ST_DRAIN);
  assign accept      = in_valid && !in_stall;
  assign append      = accept && (command == lcs_pkg::CMD_APPEND);
  assign load_result = (state == ST_DRAIN) && (drain_cnt == '0) && !(out_valid && out_stall);

  assign ctl.query     = accept && (command == lcs_pkg::CMD_QUERY);
  assign ctl.ref_clear = accept && (command == lcs_pkg::CMD_CLEAR);
  assign ctl.row_clear = ctl.ref_clear || load_result;

  assign run_chain[0]   = '0;
  assign carry_chain[0] = '0;

  for (genvar i = 0; i < MAX_REF; i++) begin : g_cell
    lcs_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .load      (append && (ref_count == CW'(i))),
      .symbol    (symbol),
      .left_run  (run_chain[i]),
      .left_carry(carry_chain[i]),
      .run       (run_chain[i+1]),
      .carry     (carry_chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      match_length        <= carry_chain[MAX_REF];
      reference_truncated <= overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      ref_count <= '0;
      drain_cnt <= '0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !load_result) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_RUN: begin
          if (ctl.ref_clear) begin
            ref_count <= '0;
            overflow  <= 1'b0;
          end else if (append) begin
            if (ref_count < CW'(MAX_REF)) begin
              ref_count <= ref_count + CW'(1);
            end else begin
              overflow <= 1'b1;
            end
          end else if (accept && (command == lcs_pkg::CMD_END)) begin
            drain_cnt <= DW'(MAX_REF - 1);
            state     <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (drain_cnt != '0) begin
            drain_cnt <= drain_cnt - DW'(1);
          end else if (load_result) begin
            out_valid <= 1'b1;
            state     <= ST_RUN;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

endmodule

// ----- design/lcs_cell.sv -----
module lcs_cell (
  input  logic              clk,
  input  logic              rst,
  input  lcs_pkg::cell_ctl_t ctl,
  input  logic              load,
  input  logic [7:0]        symbol,
  input  lcs_pkg::len_t     left_run,
  input  lcs_pkg::len_t     left_carry,
  output lcs_pkg::len_t     run,
  output lcs_pkg::len_t     carry
);

  logic          active;
  logic [7:0]    ref_byte;
  lcs_pkg::len_t best;
  lcs_pkg::len_t run_next;

  always_comb begin
    run_next = '0;
    if (ref_byte == symbol) begin
      if (left_run == lcs_pkg::LEN_MAX) begin
        run_next = lcs_pkg::LEN_MAX;
      end else begin
        run_next = left_run + lcs_pkg::len_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ref_byte <= symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      run    <= '0;
      best   <= '0;
      carry  <= '0;
    end else begin
      if (ctl.ref_clear) begin
        active <= 1'b0;
      end else if (load) begin
        active <= 1'b1;
      end
      if (ctl.row_clear) begin
        run   <= '0;
        best  <= '0;
        carry <= '0;
      end else begin
        if (load) begin
          run <= '0;
        end else if (ctl.query && active) begin
          run <= run_next;
          if (run_next > best) begin
            best <= run_next;
          end
        end
        carry <= (left_carry > best) ? left_carry : best;
      end
    end
  end

endmodule

// ----- design/lcs_checker.sv -----
module lcs_checker #(
  parameter int MAX_REF = 64
) (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] command,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] match_length,
  input logic       reference_truncated
);

  localparam int Limit = (MAX_REF < 127) ? MAX_REF : 127;

  logic end_accept;
  logic clear_accept;

  assign end_accept   = in_valid && !in_stall && (command == lcs_pkg::CMD_END);
  assign clear_accept = in_valid && !in_stall && (command == lcs_pkg::CMD_CLEAR);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(match_length)
      && $stable(reference_truncated))
    else $error("held result changed or vanished");

  a_end_stalls: assert property (@(posedge clk) disable iff (rst)
    end_accept |=> in_stall && !$rose(out_valid))
    else $error("end of query did not start the maximum sweep");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> match_length <= 7'(Limit))
    else $error("match length exceeds the reference capacity");

  a_clear_no_trunc: assert property (@(posedge clk) disable iff (rst)
    clear_accept ##1 (end_accept && !out_valid)
      |=> ##(MAX_REF) out_valid && !reference_truncated)
    else $error("truncation flag survived a clear");

endmodule

bind longest_common_substring_length lcs_checker #(.MAX_REF(MAX_REF)) u_lcs_checker (
  .clk                (clk),
  .rst                (rst),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .command            (command),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .match_length       (match_length),
  .reference_truncated(reference_truncated)
);
